// ===== rtl/tash_pkg.sv =====
// Shared types and codes for the two-axis stall homing sequencer.
package tash_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_DRIVE_DUTY        = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_YAW_HOME_DIR      = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_PITCH_HOME_DIR    = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_STALL_WINDOW      = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_MOVE_THRESHOLD    = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_MAX_DRIVE_SAMPLES = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_SETTLE_COUNT      = 3'd6;

  // Reported status codes.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;
  localparam logic [2:0] ST_ABORT   = 3'd5;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic SEL_YAW   = 1'b0;
  localparam logic SEL_PITCH = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PRIME  = 3'd1,
    PH_DRIVE  = 3'd2,
    PH_SETTLE = 3'd3,
    PH_FINAL  = 3'd4,
    PH_ENDED  = 3'd5
  } phase_t;

  typedef struct packed {
    logic               action;
    logic signed [15:0] yaw_count;
    logic signed [15:0] pitch_count;
    logic               run_enable;
  } in_item_t;

  typedef struct packed {
    logic               yaw_enable;
    logic               yaw_dir;
    logic               pitch_enable;
    logic               pitch_dir;
    logic [15:0]        duty_out;
    logic [2:0]         status;
    logic signed [15:0] yaw_home;
    logic [15:0]        yaw_span;
    logic signed [15:0] pitch_home;
    logic [15:0]        pitch_span;
  } out_item_t;

  typedef struct packed {
    logic [15:0] drive_duty;
    logic        yaw_home_dir;
    logic        pitch_home_dir;
    logic [15:0] stall_window;
    logic [15:0] move_threshold;
    logic [15:0] max_drive_samples;
    logic [15:0] settle_count;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic               axis_sel;
    logic               toward_home;
    logic signed [15:0] last_moving;
    logic [15:0]        stagnant_run;
    logic [15:0]        drive_index;
    logic [15:0]        settle_index;
    logic signed [15:0] far_stop;
    logic signed [15:0] near_stop;
    logic               stop_found;
    logic [2:0]         end_status;
    logic signed [15:0] yaw_home;
    logic [15:0]        yaw_span;
    logic signed [15:0] pitch_home;
    logic [15:0]        pitch_span;
  } state_t;

endpackage

// ===== rtl/tash_step.sv =====
// Next-state and result logic for one sequencer step.
module tash_step import tash_pkg::*; (
  input  state_t    state,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output state_t    state_next,
  output out_item_t result
);

  logic               run;
  logic signed [15:0] count;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [15:0]        stag_upd;
  logic [15:0]        index_inc;
  logic               begin_settle;
  logic               end_settle;
  logic signed [16:0] span_diff;
  logic [16:0]        span_abs;
  logic [15:0]        span;
  logic               home_dir;
  logic               drive_dir;

  assign run   = item.run_enable;
  assign count = (state.axis_sel == SEL_YAW) ? item.yaw_count : item.pitch_count;
  assign diff  = {count[15], count} - {state.last_moving[15], state.last_moving};
  assign mag   = diff[16] ? 17'(-diff) : 17'(diff);

  always_comb begin
    if (mag >= {1'b0, cfg.move_threshold}) begin
      stag_upd = '0;
    end else if (state.stagnant_run != 16'hFFFF) begin
      stag_upd = state.stagnant_run + 16'd1;
    end else begin
      stag_upd = state.stagnant_run;
    end
  end

  // Drive and settle indexes never pass their limits, so 16 bits suffice.
  assign index_inc = state.drive_index + 16'd1;

  always_comb begin
    state_next   = state;
    begin_settle = 1'b0;
    end_settle   = 1'b0;
    span_diff    = '0;
    span_abs     = '0;
    span         = '0;

    if (item.action == ACT_START) begin
      state_next.axis_sel     = SEL_YAW;
      state_next.toward_home  = 1'b0;
      state_next.last_moving  = '0;
      state_next.far_stop     = '0;
      state_next.near_stop    = '0;
      state_next.stagnant_run = '0;
      state_next.drive_index  = '0;
      state_next.settle_index = '0;
      state_next.stop_found   = 1'b0;
      state_next.end_status   = ST_BUSY;
      state_next.yaw_home     = '0;
      state_next.yaw_span     = '0;
      state_next.pitch_home   = '0;
      state_next.pitch_span   = '0;
      state_next.phase        = PH_PRIME;
    end else begin
      unique case (state.phase)
        PH_PRIME: begin
          state_next.last_moving  = count;
          state_next.stagnant_run = '0;
          state_next.drive_index  = '0;
          if ((cfg.max_drive_samples != 16'd0) && run) begin
            state_next.phase = PH_DRIVE;
          end else begin
            state_next.stop_found = 1'b0;
            begin_settle          = 1'b1;
          end
        end
        PH_DRIVE: begin
          if (mag >= {1'b0, cfg.move_threshold}) begin
            state_next.last_moving = count;
          end
          state_next.stagnant_run = stag_upd;
          if ((state.drive_index >= cfg.stall_window) && (stag_upd >= cfg.stall_window)) begin
            if (!state.toward_home) begin
              state_next.far_stop = count;
            end else begin
              state_next.near_stop = count;
            end
            state_next.stop_found = 1'b1;
            begin_settle          = 1'b1;
          end else begin
            state_next.drive_index = index_inc;
            if (!((index_inc < cfg.max_drive_samples) && run)) begin
              state_next.stop_found = 1'b0;
              begin_settle          = 1'b1;
            end
          end
        end
        PH_SETTLE: begin
          state_next.settle_index = state.settle_index + 16'd1;
          if (!((state_next.settle_index < cfg.settle_count) && run)) begin
            end_settle = 1'b1;
          end
        end
        PH_FINAL: begin
          state_next.phase      = PH_ENDED;
          state_next.end_status = ST_DONE;
        end
        default: begin
        end
      endcase
    end

    if (begin_settle) begin
      state_next.settle_index = '0;
      if ((cfg.settle_count != 16'd0) && run) begin
        state_next.phase = PH_SETTLE;
      end else begin
        end_settle = 1'b1;
      end
    end

    // End of a settle period: move on to the next stop, the next axis or the end.
    if (end_settle) begin
      span_diff = {state_next.far_stop[15], state_next.far_stop}
                - {state_next.near_stop[15], state_next.near_stop};
      span_abs  = span_diff[16] ? 17'(-span_diff) : 17'(span_diff);
      span      = span_abs[15:0];
      if (!state_next.stop_found) begin
        state_next.phase      = PH_ENDED;
        state_next.end_status = run ? ST_TIMEOUT : ST_ABORT;
      end else if (!state.toward_home) begin
        state_next.toward_home = 1'b1;
        state_next.phase       = PH_PRIME;
      end else if (span == 16'd0) begin
        state_next.phase      = PH_ENDED;
        state_next.end_status = ST_RANGE;
      end else if (state.axis_sel == SEL_YAW) begin
        state_next.yaw_home    = state_next.near_stop;
        state_next.yaw_span    = span;
        state_next.axis_sel    = SEL_PITCH;
        state_next.toward_home = 1'b0;
        state_next.phase       = PH_PRIME;
      end else begin
        state_next.pitch_home = state_next.near_stop;
        state_next.pitch_span = span;
        state_next.phase      = PH_FINAL;
      end
    end
  end

  assign home_dir  = (state_next.axis_sel == SEL_YAW) ? cfg.yaw_home_dir : cfg.pitch_home_dir;
  assign drive_dir = state_next.toward_home ? home_dir : ~home_dir;

  always_comb begin
    result              = '0;
    if (state_next.phase == PH_DRIVE) begin
      if (state_next.axis_sel == SEL_YAW) begin
        result.yaw_enable = 1'b1;
        result.yaw_dir    = drive_dir;
      end else begin
        result.pitch_enable = 1'b1;
        result.pitch_dir    = drive_dir;
      end
      result.duty_out = cfg.drive_duty;
    end
    if (state_next.phase == PH_IDLE) begin
      result.status = ST_IDLE;
    end else if (state_next.phase == PH_ENDED) begin
      result.status = state_next.end_status;
    end else begin
      result.status = ST_BUSY;
    end
    result.yaw_home   = state_next.yaw_home;
    result.yaw_span   = state_next.yaw_span;
    result.pitch_home = state_next.pitch_home;
    result.pitch_span = state_next.pitch_span;
  end

endmodule

// ===== rtl/two_axis_stall_homing.sv =====
// Top level of the two-axis stall homing sequencer.
//
//  channel  direction  payload      handshake
//  in       input      in_item_t    in_valid / in_stall
//  out      output     out_item_t   out_valid / out_stall
//  cfg      input      16-bit data  cfg_write, cfg_index
//
// Each transaction is registered at the input, stepped through the sequencer
// logic and registered at the output. A new transaction can be taken every
// cycle while in_stall is low; the sequencer state is the only loop. in_stall
// rises only when both the input and output registers are full and out_stall
// is high. Reset is synchronous and restores the register defaults and the
// idle state.
module two_axis_stall_homing import tash_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  in_item_t  in_reg;
  logic      in_full;
  out_item_t step_result;
  logic      advance;

  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;

  tash_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (in_reg),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_duty        <= 16'd200;
      cfg.yaw_home_dir      <= 1'b0;
      cfg.pitch_home_dir    <= 1'b0;
      cfg.stall_window      <= 16'd20;
      cfg.move_threshold    <= 16'd2;
      cfg.max_drive_samples <= 16'd2000;
      cfg.settle_count      <= 16'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DRIVE_DUTY:        cfg.drive_duty        <= cfg_data;
        CFG_YAW_HOME_DIR:      cfg.yaw_home_dir      <= cfg_data[0];
        CFG_PITCH_HOME_DIR:    cfg.pitch_home_dir    <= cfg_data[0];
        CFG_STALL_WINDOW:      cfg.stall_window      <= cfg_data;
        CFG_MOVE_THRESHOLD:    cfg.move_threshold    <= cfg_data;
        CFG_MAX_DRIVE_SAMPLES: cfg.max_drive_samples <= cfg_data;
        CFG_SETTLE_COUNT:      cfg.settle_count      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, axis_sel: SEL_YAW, end_status: ST_IDLE, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule
